### rtl/core/fse_pkg.sv
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types, widths and constants of the span fill engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fse_pkg;

   // field widths
   localparam int CMD_W      = 3;
   localparam int COORD_W    = 12;
   localparam int COLOR_W    = 16;
   localparam int WREG_W     = 10;
   localparam int HREG_W     = 9;
   localparam int WREG_MAX   = 2**WREG_W - 1;
   localparam int HREG_MAX   = 2**HREG_W - 1;
   // width of W*H for the largest register values
   localparam int PROD_W     = WREG_W + HREG_W;

   // frame store defaults
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 256;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = WREG_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = CSR_IDX_W'(1);
   localparam logic [WREG_W-1:0] RST_SCREEN_WIDTH  = WREG_W'(320);
   localparam logic [HREG_W-1:0] RST_SCREEN_HEIGHT = HREG_W'(200);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 3'd0,
      CMD_HORIZON = 3'd1,
      CMD_PIXEL   = 3'd2,
      CMD_HSPAN   = 3'd3,
      CMD_VSPAN   = 3'd4,
      CMD_FILL    = 3'd5,
      CMD_OUTLINE = 3'd6,
      CMD_READ    = 3'd7
   } cmd_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  span_end;
      logic signed [COORD_W-1:0]  rect_w;
      logic signed [COORD_W-1:0]  rect_h;
      logic [COLOR_W-1:0]         color;
      logic [COLOR_W-1:0]         floor_color;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_PLAN,
      ST_CLIP,
      ST_MUL,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } seq_state_type;

   // sequencer to walker
   typedef struct packed {
      logic start;
      logic rd;
      logic vert;
   } walk_ctl_type;

   // walker to sequencer
   typedef struct packed {
      logic busy;
   } walk_stat_type;

   // saturate a 14-bit signed sum to the 12-bit coordinate range
   function automatic logic signed [COORD_W-1:0] sat12(input logic signed [13:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 14'sd2047) begin
         r = 12'sd2047;
      end else if (v < -14'sd2048) begin
         r = -12'sd2048;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/fse_if.sv
// ----------------------------------------------------------------------------
// fse_if
// Valid/ready channels of the span fill engine: command, response, registers.
// ----------------------------------------------------------------------------
`default_nettype none

interface fse_req_if;
   import fse_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] span_end;
   logic signed [COORD_W-1:0] rect_w;
   logic signed [COORD_W-1:0] rect_h;
   logic [COLOR_W-1:0]        color;
   logic [COLOR_W-1:0]        floor_color;

   modport source (output valid, command, pos_x, pos_y, span_end, rect_w, rect_h,
                   color, floor_color, input ready);
   modport sink   (input valid, command, pos_x, pos_y, span_end, rect_w, rect_h,
                   color, floor_color, output ready);
endinterface

interface fse_rsp_if;
   import fse_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] read_color;
   logic               in_bounds;

   modport source (output valid, read_color, in_bounds, input ready);
   modport sink   (input valid, read_color, in_bounds, output ready);
endinterface

interface fse_csr_if;
   import fse_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/fse_walk.sv
// ----------------------------------------------------------------------------
// fse_walk
// Frame store and span walker: writes one pixel per cycle while stepping the
// address by 1 or by the screen width; serves single-pixel reads.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_walk #(
   parameter  int MAX_WIDTH  = fse_pkg::DEF_MAX_WIDTH,
   parameter  int MAX_HEIGHT = fse_pkg::DEF_MAX_HEIGHT,
   localparam int Depth      = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW         = $clog2(Depth),
   localparam int CW         = AW + 1
) (
   input  wire                           clock,
   input  wire                           reset,
   input  fse_pkg::walk_ctl_type         ctl,
   input  wire [AW-1:0]                  addr,
   input  wire [CW-1:0]                  cnt,
   input  wire [fse_pkg::COLOR_W-1:0]    color,
   input  wire [fse_pkg::WREG_W-1:0]     eff_w,
   output fse_pkg::walk_stat_type        stat,
   output logic [fse_pkg::COLOR_W-1:0]   rd_data
);
   import fse_pkg::*;

   logic [COLOR_W-1:0] frame_ff [Depth];

   logic               busy_ff, busy_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               vert_ff, vert_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [COLOR_W-1:0] rd_q_ff;
   logic [AW-1:0]      stride;

   assign stride = vert_ff ? AW'(eff_w) : AW'(1);

   always_comb begin
      busy_in  = busy_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      vert_in  = vert_ff;
      color_in = color_ff;
      if (busy_ff) begin
         addr_in = addr_ff + stride;
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end else if (ctl.start && !ctl.rd) begin
         addr_in  = addr;
         cnt_in   = cnt;
         vert_in  = ctl.vert;
         color_in = color;
         busy_in  = (cnt != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      vert_ff  <= vert_in;
      color_ff <= color_in;
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         frame_ff[addr_ff] <= color_ff;
      end
      if (ctl.start && ctl.rd) begin
         rd_q_ff <= frame_ff[addr];
      end
   end

   assign stat.busy = busy_ff;
   assign rd_data   = rd_q_ff;

endmodule

`default_nettype wire

### rtl/core/fse_seq.sv
// ----------------------------------------------------------------------------
// fse_seq
// Command sequencer: breaks a command into spans, clips each drawn span (full-screen
// clear and horizon spans excepted) to the screen, forms its start address and hands it to the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_seq #(
   parameter  int MAX_WIDTH  = fse_pkg::DEF_MAX_WIDTH,
   parameter  int MAX_HEIGHT = fse_pkg::DEF_MAX_HEIGHT,
   localparam int Depth      = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW         = $clog2(Depth),
   localparam int CW         = AW + 1
) (
   input  wire                           clock,
   input  wire                           reset,
   input  fse_pkg::item_type             item,
   input  wire                           item_take,
   input  wire [fse_pkg::WREG_W-1:0]     eff_w,
   input  wire [fse_pkg::HREG_W-1:0]     eff_h,
   input  wire                           out_free,
   output logic                          ready,
   output logic                          done,
   output logic [fse_pkg::COLOR_W-1:0]   res_color,
   output logic                          res_inb,
   output fse_pkg::walk_ctl_type         walk_ctl,
   output logic [AW-1:0]                 walk_addr,
   output logic [CW-1:0]                 walk_cnt,
   output logic [fse_pkg::COLOR_W-1:0]   walk_color,
   input  fse_pkg::walk_stat_type        walk_stat,
   input  wire [fse_pkg::COLOR_W-1:0]    rd_data
);
   import fse_pkg::*;

   localparam int XW = (AW + 1 > PROD_W) ? AW + 1 : PROD_W;

   seq_state_type state_ff, state_in;

   item_type                  item_ff, item_in;
   logic signed [COORD_W-1:0] xe_ff, xe_in, ye_ff, ye_in, xl_ff, xl_in, yl_ff, yl_in;
   logic                      rect_ok_ff, rect_ok_in;
   logic [XW-1:0]             tot_ff, tot_in;
   logic signed [12:0]        rr_ff, rr_in;
   logic [1:0]                idx_ff, idx_in;
   logic                      last_ff, last_in;
   logic                      sp_vert_ff, sp_vert_in;
   logic signed [12:0]        sp_fix_ff, sp_fix_in, sp_lo_ff, sp_lo_in, sp_hi_ff, sp_hi_in;
   logic [COLOR_W-1:0]        sp_color_ff, sp_color_in;
   logic [HREG_W-1:0]         row_ff, row_in;
   logic [WREG_W-1:0]         colm_ff, colm_in;
   logic                      ok_ff, ok_in;
   logic [XW-1:0]             iss_base_ff, iss_base_in, iss_cnt_ff, iss_cnt_in;

   // shared multiplier: W*H during setup, row*W per span
   logic [HREG_W-1:0] mul_a;
   logic [PROD_W-1:0] prod;
   assign mul_a = (state_ff == ST_PREP) ? eff_h : row_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(eff_w);

   logic signed [12:0] w13, h13, px13, py13, se13;
   logic [XW-1:0]      half;
   assign w13  = signed'({3'b000, eff_w});
   assign h13  = signed'({4'b0000, eff_h});
   assign px13 = 13'(item_ff.pos_x);
   assign py13 = 13'(item_ff.pos_y);
   assign se13 = 13'(item_ff.span_end);
   assign half = tot_ff >> 1;

   // span plan for the current command step
   logic               pl_stop, pl_lin, pl_last, pl_vert;
   logic signed [12:0] pl_fix, pl_lo, pl_hi;
   logic [COLOR_W-1:0] pl_color;
   logic [XW-1:0]      pl_base, pl_cnt;

   always_comb begin
      pl_stop  = 1'b0;
      pl_lin   = 1'b0;
      pl_last  = 1'b1;
      pl_vert  = 1'b0;
      pl_fix   = py13;
      pl_lo    = px13;
      pl_hi    = px13 + 13'sd1;
      pl_color = item_ff.color;
      pl_base  = '0;
      pl_cnt   = tot_ff;
      case (item_ff.command)
         CMD_CLEAR: begin
            pl_lin = 1'b1;
         end
         CMD_HORIZON: begin
            pl_lin = 1'b1;
            pl_cnt = half;
            if (idx_ff == 2'd0) begin
               pl_last = 1'b0;
            end else begin
               pl_base  = half;
               pl_color = item_ff.floor_color;
            end
         end
         CMD_HSPAN: begin
            pl_hi = se13;
         end
         CMD_VSPAN: begin
            pl_vert = 1'b1;
            pl_fix  = px13;
            pl_lo   = py13;
            pl_hi   = se13;
         end
         CMD_FILL: begin
            pl_last = 1'b0;
            pl_fix  = rr_ff;
            pl_hi   = 13'(xe_ff);
            pl_stop = !rect_ok_ff || !(rr_ff < 13'(ye_ff) && rr_ff < h13);
         end
         CMD_OUTLINE: begin
            pl_stop = !rect_ok_ff;
            pl_last = (idx_ff == 2'd3);
            case (idx_ff)
               2'd0: begin
                  pl_hi = 13'(xe_ff);
               end
               2'd1: begin
                  pl_vert = 1'b1;
                  pl_fix  = px13;
                  pl_lo   = py13;
                  pl_hi   = 13'(ye_ff);
               end
               2'd2: begin
                  pl_vert = 1'b1;
                  pl_fix  = 13'(xl_ff);
                  pl_lo   = py13;
                  pl_hi   = 13'(ye_ff);
               end
               default: begin
                  pl_fix = 13'(yl_ff);
                  pl_hi  = 13'(xe_ff);
               end
            endcase
         end
         default: begin
            // pixel and read: one-pixel horizontal span
         end
      endcase
   end

   // clip the planned span to the screen
   logic signed [12:0] lim_f, lim_r, lo_c, hi_c, span_n;
   logic               clip_ok;
   assign lim_f   = sp_vert_ff ? w13 : h13;
   assign lim_r   = sp_vert_ff ? h13 : w13;
   assign lo_c    = sp_lo_ff[12] ? 13'sd0 : sp_lo_ff;
   assign hi_c    = (sp_hi_ff > lim_r) ? lim_r : sp_hi_ff;
   assign span_n  = hi_c - lo_c;
   assign clip_ok = !sp_fix_ff[12] && (sp_fix_ff < lim_f) && (hi_c > lo_c);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_take) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            if (pl_stop) begin
               state_in = ST_DONE;
            end else if (pl_lin) begin
               state_in = ST_ISSUE;
            end else begin
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            if (clip_ok) begin
               state_in = ST_MUL;
            end else if (last_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PLAN;
            end
         end
         ST_MUL: begin
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!walk_stat.busy) state_in = last_ff ? ST_DONE : ST_PLAN;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      item_in     = item_ff;
      xe_in       = xe_ff;
      ye_in       = ye_ff;
      xl_in       = xl_ff;
      yl_in       = yl_ff;
      rect_ok_in  = rect_ok_ff;
      tot_in      = tot_ff;
      rr_in       = rr_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      sp_vert_in  = sp_vert_ff;
      sp_fix_in   = sp_fix_ff;
      sp_lo_in    = sp_lo_ff;
      sp_hi_in    = sp_hi_ff;
      sp_color_in = sp_color_ff;
      row_in      = row_ff;
      colm_in     = colm_ff;
      ok_in       = ok_ff;
      iss_base_in = iss_base_ff;
      iss_cnt_in  = iss_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_take) begin
               item_in = item;
               idx_in  = 2'd0;
            end
         end
         ST_PREP: begin
            xe_in      = sat12(14'(item_ff.pos_x) + 14'(item_ff.rect_w));
            ye_in      = sat12(14'(item_ff.pos_y) + 14'(item_ff.rect_h));
            xl_in      = sat12(14'(item_ff.pos_x) + 14'(item_ff.rect_w) - 14'sd1);
            yl_in      = sat12(14'(item_ff.pos_y) + 14'(item_ff.rect_h) - 14'sd1);
            rect_ok_in = (item_ff.rect_w > 12'sd0) && (item_ff.rect_h > 12'sd0);
            tot_in     = XW'(prod);
            rr_in      = py13[12] ? 13'sd0 : py13;
         end
         ST_PLAN: begin
            if (!pl_stop) begin
               last_in     = pl_last;
               sp_vert_in  = pl_vert;
               sp_fix_in   = pl_fix;
               sp_lo_in    = pl_lo;
               sp_hi_in    = pl_hi;
               sp_color_in = pl_color;
               idx_in      = idx_ff + 2'd1;
               if (item_ff.command == CMD_FILL) rr_in = rr_ff + 13'sd1;
               if (pl_lin) begin
                  iss_base_in = pl_base;
                  iss_cnt_in  = pl_cnt;
               end
            end
         end
         ST_CLIP: begin
            row_in     = sp_vert_ff ? lo_c[HREG_W-1:0] : sp_fix_ff[HREG_W-1:0];
            colm_in    = sp_vert_ff ? sp_fix_ff[WREG_W-1:0] : lo_c[WREG_W-1:0];
            ok_in      = clip_ok;
            iss_cnt_in = XW'(span_n[WREG_W:0]);
         end
         ST_MUL: begin
            iss_base_in = XW'(prod) + XW'(colm_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      xe_ff       <= xe_in;
      ye_ff       <= ye_in;
      xl_ff       <= xl_in;
      yl_ff       <= yl_in;
      rect_ok_ff  <= rect_ok_in;
      tot_ff      <= tot_in;
      rr_ff       <= rr_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      sp_vert_ff  <= sp_vert_in;
      sp_fix_ff   <= sp_fix_in;
      sp_lo_ff    <= sp_lo_in;
      sp_hi_ff    <= sp_hi_in;
      sp_color_ff <= sp_color_in;
      row_ff      <= row_in;
      colm_ff     <= colm_in;
      ok_ff       <= ok_in;
      iss_base_ff <= iss_base_in;
      iss_cnt_ff  <= iss_cnt_in;
   end

   // outputs
   always_comb begin
      ready          = (state_ff == ST_IDLE);
      done           = (state_ff == ST_DONE) && out_free;
      walk_ctl.start = (state_ff == ST_ISSUE);
      walk_ctl.rd    = (item_ff.command == CMD_READ);
      walk_ctl.vert  = sp_vert_ff;
      walk_addr      = iss_base_ff[AW-1:0];
      walk_cnt       = iss_cnt_ff[CW-1:0];
      walk_color     = sp_color_ff;
      res_inb        = (item_ff.command == CMD_READ) && ok_ff;
      res_color      = res_inb ? rd_data : '0;
   end

endmodule

`default_nettype wire

### rtl/core/framebuffer_span_fill_engine_core.sv
// ----------------------------------------------------------------------------
// framebuffer_span_fill_engine_core
// 2D fill engine over an RGB565 frame store: clear, horizon clear, pixel,
// clipped spans, filled and outline rectangles, and single-pixel read-back.
// ----------------------------------------------------------------------------
//
//  channel | dir | transfer when        | carries
//  --------+-----+----------------------+------------------------------------
//  req_ch  | in  | valid & ready        | command, coordinates, colors
//  rsp_ch  | out | valid & ready        | read_color, in_bounds (one per cmd)
//  csr_ch  | in  | valid & ready        | index 0 screen_width, 1 screen_height
//
//  Pixels are written one per cycle through the single frame store write port;
//  each span also passes through plan, clip, row*W multiply, issue and drain
//  states, and each command through setup and done. Clear and horizon spans
//  skip clip and multiply. The walker's single write port bounds the fill rate.
//  Reset clears control state only; the frame store holds garbage until drawn.
//  A command is taken only when idle; a response held by rsp_ch backpressure
//  stalls the next command after the current one finishes.
`default_nettype none

module framebuffer_span_fill_engine_core #(
   parameter int MAX_WIDTH  = fse_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fse_pkg::DEF_MAX_HEIGHT
) (
   input  wire    clock,
   input  wire    reset,
   fse_req_if.sink   req_ch,
   fse_rsp_if.source rsp_ch,
   fse_csr_if.sink   csr_ch
);
   import fse_pkg::*;

   localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = AW + 1;

   // register values above the store size saturate
   localparam logic [WREG_W-1:0] W_CAP =
      WREG_W'((MAX_WIDTH > WREG_MAX) ? WREG_MAX : MAX_WIDTH);
   localparam logic [HREG_W-1:0] H_CAP =
      HREG_W'((MAX_HEIGHT > HREG_MAX) ? HREG_MAX : MAX_HEIGHT);

   // ---- configuration registers ----
   logic [WREG_W-1:0] scr_w_ff, scr_w_in;
   logic [HREG_W-1:0] scr_h_ff, scr_h_in;
   logic [WREG_W-1:0] eff_w;
   logic [HREG_W-1:0] eff_h;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      scr_w_in = scr_w_ff;
      scr_h_in = scr_h_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SCREEN_WIDTH:  scr_w_in = csr_ch.data[WREG_W-1:0];
            CSR_SCREEN_HEIGHT: scr_h_in = csr_ch.data[HREG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= RST_SCREEN_WIDTH;
         scr_h_ff <= RST_SCREEN_HEIGHT;
      end else begin
         scr_w_ff <= scr_w_in;
         scr_h_ff <= scr_h_in;
      end
   end

   assign eff_w = (scr_w_ff > W_CAP) ? W_CAP : scr_w_ff;
   assign eff_h = (scr_h_ff > H_CAP) ? H_CAP : scr_h_ff;

   // ---- command intake ----
   item_type item;
   logic     seq_ready;
   logic     item_take;

   assign item.command     = cmd_type'(req_ch.command);
   assign item.pos_x       = req_ch.pos_x;
   assign item.pos_y       = req_ch.pos_y;
   assign item.span_end    = req_ch.span_end;
   assign item.rect_w      = req_ch.rect_w;
   assign item.rect_h      = req_ch.rect_h;
   assign item.color       = req_ch.color;
   assign item.floor_color = req_ch.floor_color;

   assign req_ch.ready = seq_ready;
   assign item_take    = req_ch.valid && seq_ready;

   // ---- response register ----
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_inb_ff, rsp_inb_in;
   logic               out_free;
   logic               done;
   logic [COLOR_W-1:0] res_color;
   logic               res_inb;

   // slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_color_in = rsp_color_ff;
      rsp_inb_in   = rsp_inb_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_color_in = res_color;
         rsp_inb_in   = res_inb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff <= rsp_color_in;
      rsp_inb_ff   <= rsp_inb_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_color = rsp_color_ff;
   assign rsp_ch.in_bounds  = rsp_inb_ff;

   // ---- sequencer and span walker ----
   walk_ctl_type       walk_ctl;
   walk_stat_type      walk_stat;
   logic [AW-1:0]      walk_addr;
   logic [CW-1:0]      walk_cnt;
   logic [COLOR_W-1:0] walk_color;
   logic [COLOR_W-1:0] rd_data;

   fse_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_take  (item_take),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .out_free   (out_free),
      .ready      (seq_ready),
      .done       (done),
      .res_color  (res_color),
      .res_inb    (res_inb),
      .walk_ctl   (walk_ctl),
      .walk_addr  (walk_addr),
      .walk_cnt   (walk_cnt),
      .walk_color (walk_color),
      .walk_stat  (walk_stat),
      .rd_data    (rd_data)
   );

   fse_walk #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .ctl     (walk_ctl),
      .addr    (walk_addr),
      .cnt     (walk_cnt),
      .color   (walk_color),
      .eff_w   (eff_w),
      .stat    (walk_stat),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
